/* hw/rtl/ntet_pkg.sv */
// Shared types and constants for the nested trace exclusive-time block.
package ntet_pkg;

    // Width of the nesting depth field and the deepest table it can address.
    localparam int LVL_W      = 6;
    localparam int MAX_LEVELS = 1 << LVL_W;
    localparam int PORT_TIME_W = 64;

    typedef logic [LVL_W-1:0] t_lvl;

    // How the depth of a record relates to the depth of the record before it.
    typedef enum logic [1:0] {
        REL_SAME      = 2'd0,
        REL_DEEPER    = 2'd1,
        REL_SHALLOWER = 2'd2
    } t_rel;

    // Control flags carried with a word from the input register to the result logic.
    typedef struct packed {
        logic ovf;       // depth lies beyond the table
        t_rel rel;       // depth relation to the previous record
        logic vld_lvl;   // entry at the record's own depth holds data
        logic vld_prev;  // entry at the previous depth holds data
        logic fwd_lvl;   // own-depth entry was being written as it was read
        logic fwd_prev;  // previous-depth entry was being written as it was read
    } t_s1_ctl;

endpackage

/* hw/rtl/ntet_child_ram.sv */
// Child-time table: one write port and two registered read ports.
module ntet_child_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int TW    = 64
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wa,
    input  logic [TW-1:0] i_wd,
    input  logic          i_re,
    input  logic [AW-1:0] i_ra0,
    input  logic [AW-1:0] i_ra1,
    output logic [TW-1:0] o_rd0,
    output logic [TW-1:0] o_rd1
);

    logic [TW-1:0] r_mem [DEPTH];
    logic [TW-1:0] r_rd0;
    logic [TW-1:0] r_rd1;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    // Read ports; the data holds while no new read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd0 <= r_mem[i_ra0];
            r_rd1 <= r_mem[i_ra1];
        end
    end

    assign o_rd0 = r_rd0;
    assign o_rd1 = r_rd1;

endmodule

/* hw/rtl/ntet_self_calc.sv */
// Result logic: selects the table values, subtracts the children and forms the update.
module ntet_self_calc #(
    parameter int TW = 64
) (
    input  ntet_pkg::t_s1_ctl i_ctl,
    input  logic [TW-1:0]     i_dur,
    input  logic [TW-1:0]     i_rd_lvl,
    input  logic [TW-1:0]     i_rd_prev,
    input  logic [TW-1:0]     i_fwd_data,
    output logic [TW-1:0]     o_self,
    output logic              o_under,
    output logic [TW-1:0]     o_wr_data
);
    import ntet_pkg::*;

    logic [TW-1:0] cur;
    logic [TW-1:0] kids;
    logic [TW-1:0] acc;

    // An entry that is not valid reads as zero; a concurrent write is taken over.
    assign cur  = !i_ctl.vld_lvl  ? '0 : (i_ctl.fwd_lvl  ? i_fwd_data : i_rd_lvl);
    assign kids = !i_ctl.vld_prev ? '0 : (i_ctl.fwd_prev ? i_fwd_data : i_rd_prev);
    assign acc  = cur + i_dur;

    // Self time and the new value of the entry at the record's depth.
    always_comb begin
        o_self    = i_dur;
        o_under   = 1'b0;
        o_wr_data = acc;
        if (!i_ctl.ovf) begin
            unique case (i_ctl.rel)
                REL_SAME: begin
                    o_wr_data = acc;
                end
                REL_DEEPER: begin
                    o_wr_data = i_dur;
                end
                REL_SHALLOWER: begin
                    if (kids > i_dur) begin
                        o_self  = '0;
                        o_under = 1'b1;
                    end else begin
                        o_self  = i_dur - kids;
                    end
                    o_wr_data = acc;
                end
                default: begin
                    o_wr_data = acc;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/nested_trace_exclusive_time_core.sv */
// Top level of the nested trace exclusive-time block.
//
// Input channel: i_in_valid with o_in_stall carries one trace record per word
// (start and end timestamp, nesting depth, first-record flag). Output channel:
// o_out_valid with i_out_stall carries one result word per record (self time,
// underflow flag, level overflow flag), in input order.
//
// A taken record is registered into the result stage, and its result word
// moves to the output register as that stage advances. A new record can be
// taken every cycle unless the receiver stalls with both stages full: the table is
// read as the record is registered, and the result logic writes it back as
// the word leaves the result stage, with the word being written forwarded to
// the record that follows. The table is a memory with two read ports; a valid
// bit per entry lets a window start or a deeper record clear entries.
//
// Reset clears every valid bit, the previous depth and both pipeline stages;
// the block takes input as soon as reset is released. While the receiver
// stalls, the output register holds its word, and input is still taken until
// the stage in front of it is also full.
module nested_trace_exclusive_time_core #(
    parameter int LEVELS    = 64,
    parameter int TIME_BITS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ntet_pkg::PORT_TIME_W-1:0]    i_start_time,
    input  logic [ntet_pkg::PORT_TIME_W-1:0]    i_end_time,
    input  ntet_pkg::t_lvl                      i_nest_level,
    input  logic                                i_first_record,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ntet_pkg::PORT_TIME_W-1:0]    o_self_time,
    output logic                                o_underflow,
    output logic                                o_level_overflow
);
    import ntet_pkg::*;

    localparam int TAB_DEPTH = (LEVELS < MAX_LEVELS) ? LEVELS : MAX_LEVELS;
    localparam int AW        = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
    localparam int TW        = TIME_BITS;

    // Architectural state and pipeline registers.
    logic [TAB_DEPTH-1:0] r_vld,     n_vld;
    t_lvl                 r_prev,    n_prev;
    logic                 r_s1_vld;
    t_s1_ctl              r_s1_ctl,  n_s1_ctl;
    logic [TW-1:0]        r_s1_dur,  n_s1_dur;
    logic [AW-1:0]        r_s1_addr;
    logic [TW-1:0]        r_fwd_data;
    logic                 r_out_vld;
    logic [TW-1:0]        r_out_self;
    logic                 r_out_under;
    logic                 r_out_ovf;

    logic                 s1_adv;
    logic                 in_acc;
    logic                 lvl_ovf;
    t_lvl                 prev_lvl;
    logic [AW-1:0]        lvl_addr;
    logic [AW-1:0]        prev_addr;
    logic                 wr_en;
    logic [TW-1:0]        rd_lvl;
    logic [TW-1:0]        rd_prev;
    logic [TW-1:0]        calc_self;
    logic                 calc_under;
    logic [TW-1:0]        calc_wr;

    // Handshake: the result stage advances when the output register frees up.
    assign s1_adv     = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_s1_vld && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Address decode for the incoming word.
    assign lvl_ovf   = 32'(i_nest_level) >= 32'(TAB_DEPTH);
    assign prev_lvl  = i_first_record ? i_nest_level : r_prev;
    assign lvl_addr  = i_nest_level[AW-1:0];
    assign prev_addr = prev_lvl[AW-1:0];

    // The word in the result stage writes its entry as it moves on.
    assign wr_en = r_s1_vld && s1_adv && !r_s1_ctl.ovf;

    // Control flags, duration and valid-bit update for the incoming word.
    always_comb begin
        n_s1_ctl.ovf      = lvl_ovf;
        n_s1_ctl.vld_lvl  = !i_first_record && r_vld[lvl_addr];
        n_s1_ctl.vld_prev = !i_first_record && r_vld[prev_addr];
        n_s1_ctl.fwd_lvl  = wr_en && (r_s1_addr == lvl_addr);
        n_s1_ctl.fwd_prev = wr_en && (r_s1_addr == prev_addr);
        if (i_nest_level == prev_lvl) begin
            n_s1_ctl.rel = REL_SAME;
        end else if (i_nest_level > prev_lvl) begin
            n_s1_ctl.rel = REL_DEEPER;
        end else begin
            n_s1_ctl.rel = REL_SHALLOWER;
        end

        n_s1_dur = i_end_time[TW-1:0] - i_start_time[TW-1:0];

        n_vld  = r_vld;
        n_prev = r_prev;
        if (i_first_record) begin
            n_vld = '0;
        end
        if (!lvl_ovf) begin
            for (int j = 0; j < TAB_DEPTH; j++) begin
                if (t_lvl'(j) > prev_lvl && t_lvl'(j) < i_nest_level) begin
                    n_vld[j] = 1'b0;
                end
            end
            n_vld[lvl_addr] = 1'b1;
            n_prev          = i_nest_level;
        end
    end

    // Table state and the result-stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_prev   <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_vld  <= n_vld;
                r_prev <= n_prev;
            end
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    // Result-stage payload, including the word being written for forwarding.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ctl   <= n_s1_ctl;
            r_s1_dur   <= n_s1_dur;
            r_s1_addr  <= lvl_addr;
            r_fwd_data <= calc_wr;
        end
    end

    ntet_child_ram #(
        .DEPTH (TAB_DEPTH),
        .AW    (AW),
        .TW    (TW)
    ) u_ram (
        .i_clk (i_clk),
        .i_we  (wr_en),
        .i_wa  (r_s1_addr),
        .i_wd  (calc_wr),
        .i_re  (in_acc),
        .i_ra0 (lvl_addr),
        .i_ra1 (prev_addr),
        .o_rd0 (rd_lvl),
        .o_rd1 (rd_prev)
    );

    ntet_self_calc #(
        .TW (TW)
    ) u_calc (
        .i_ctl      (r_s1_ctl),
        .i_dur      (r_s1_dur),
        .i_rd_lvl   (rd_lvl),
        .i_rd_prev  (rd_prev),
        .i_fwd_data (r_fwd_data),
        .o_self     (calc_self),
        .o_under    (calc_under),
        .o_wr_data  (calc_wr)
    );

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_vld) begin
            r_out_self  <= calc_self;
            r_out_under <= calc_under;
            r_out_ovf   <= r_s1_ctl.ovf;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_self_time      = PORT_TIME_W'(r_out_self);
    assign o_underflow      = r_out_under;
    assign o_level_overflow = r_out_ovf;

endmodule

/* dv/tb_nested_trace_exclusive_time_core.sv */
// Self-checking testbench for the nested trace exclusive-time block.
module tb_nested_trace_exclusive_time_core;
    import ntet_pkg::*;

    localparam int          LEVELS     = 64;
    localparam int          TIME_BITS  = 64;
    localparam logic [63:0] TIME_MASK  = {64{1'b1}} >> (64 - TIME_BITS);
    localparam int          PHASE_ITEMS = 275;
    localparam int          QUIET_LIMIT = 5000;
    localparam int          MAX_PRINTS  = 40;

    // One trace record as it is sent, tagged with the idling phase it belongs to.
    typedef struct {
        logic [63:0] start_ts;
        logic [63:0] end_ts;
        t_lvl        depth;
        logic        first;
        int          phase;
    } trace_rec_t;

    // One result word as the block should give it.
    typedef struct {
        logic [63:0] self_t;
        logic        under;
        logic        over;
    } self_res_t;

    // Idling per phase: none, sender idle, receiver stalling, both.
    int unsigned send_idle_pct [4] = '{0, 74, 0, 31};
    int unsigned rx_stall_pct  [4] = '{0, 0, 74, 31};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [63:0] i_start_time = '0;
    logic [63:0] i_end_time = '0;
    t_lvl        i_nest_level = '0;
    logic        i_first_record = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [63:0] o_self_time;
    logic        o_underflow;
    logic        o_level_overflow;

    trace_rec_t  records_to_send [$];
    trace_rec_t  rec_on_bus;
    self_res_t   predicted_self_times [$];
    int          cur_phase = 0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          quiet_cycles = 0;

    // Model state: accumulated child time per depth and the previous depth.
    logic [63:0] child_time [MAX_LEVELS];
    int unsigned last_depth;

    nested_trace_exclusive_time_core #(
        .LEVELS    (LEVELS),
        .TIME_BITS (TIME_BITS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_start_time     (i_start_time),
        .i_end_time       (i_end_time),
        .i_nest_level     (i_nest_level),
        .i_first_record   (i_first_record),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_self_time      (o_self_time),
        .o_underflow      (o_underflow),
        .o_level_overflow (o_level_overflow)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Prints one line for a mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Works out the exclusive time of one record and updates the depth table.
    function automatic self_res_t compute_self_time(trace_rec_t r);
        logic [63:0] dur;
        logic [63:0] kids;
        int unsigned lvl;
        int unsigned prev;
        self_res_t   res;
        dur = ((r.end_ts & TIME_MASK) - (r.start_ts & TIME_MASK)) & TIME_MASK;
        lvl = r.depth;
        res.self_t = dur;
        res.under = 1'b0;
        res.over = 1'b0;
        if (r.first) begin
            for (int j = 0; j < MAX_LEVELS; j++) child_time[j] = '0;
        end
        if (lvl >= LEVELS) begin
            res.over = 1'b1;
        end else begin
            prev = r.first ? lvl : last_depth;
            if (prev >= LEVELS) prev = lvl;
            if (lvl == prev) begin
                child_time[lvl] = (child_time[lvl] + dur) & TIME_MASK;
            end else if (lvl > prev) begin
                // Levels skipped on the way down hold nothing yet.
                for (int j = prev + 1; j < lvl; j++) child_time[j] = '0;
                child_time[lvl] = dur;
            end else begin
                kids = child_time[prev];
                if (kids > dur) begin
                    res.self_t = '0;
                    res.under = 1'b1;
                end else begin
                    res.self_t = dur - kids;
                end
                child_time[lvl] = (child_time[lvl] + dur) & TIME_MASK;
            end
            last_depth = lvl;
        end
        res.self_t = res.self_t & TIME_MASK;
        return res;
    endfunction

    task automatic add_rec(input logic [63:0] s, input logic [63:0] e, input int d,
                           input logic f, input int ph);
        trace_rec_t r;
        r.start_ts = s;
        r.end_ts = e;
        r.depth = t_lvl'(d);
        r.first = f;
        r.phase = ph;
        records_to_send = {records_to_send, r};
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // A window of properly nested calls, emitted in end order, with a few
    // records dropped or damaged to give broken sequences.
    task automatic gen_window(input int ph);
        logic [63:0] now;
        logic [63:0] open_starts [$];
        logic [63:0] s;
        int          max_nest;
        int          base;
        int          closes;
        int          n_closes;
        int          roll;
        int          d;
        logic        first_due;
        max_nest = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        base = $urandom_range(0, 64 - max_nest);
        n_closes = $urandom_range(4, 40);
        closes = 0;
        first_due = ($urandom_range(9) != 0);
        case ($urandom_range(2))
            0: now = rand64();
            1: now = 64'hFFFF_FFFF_FFFF_FC00 + $urandom_range(1023);
            default: now = $urandom_range(1000);
        endcase
        while (closes < n_closes || open_starts.size() != 0) begin
            if (open_starts.size() == 0 ||
                (open_starts.size() < max_nest && closes < n_closes &&
                 $urandom_range(1) == 0)) begin
                open_starts = {open_starts, now};
            end else begin
                s = open_starts.pop_back();
                d = base + open_starts.size();
                closes++;
                roll = $urandom_range(99);
                if (roll < 3) begin
                    // Record lost from the stream.
                end else if (roll < 6) begin
                    add_rec(s, now, $urandom_range(63), first_due, ph);
                    first_due = 1'b0;
                end else if (roll < 8) begin
                    add_rec(now, s, d, first_due, ph);
                    first_due = 1'b0;
                end else begin
                    add_rec(s, now, d, first_due, ph);
                    first_due = 1'b0;
                end
            end
            if ($urandom_range(19) == 0)
                now = now + (rand64() >> $urandom_range(63));
            else
                now = now + $urandom_range(50);
        end
    endtask

    // Sends records and predicts each result as its word is taken.
    always @(posedge i_clk) begin
        logic busy;
        trace_rec_t nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            busy = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                predicted_self_times = {predicted_self_times,
                                        compute_self_time(rec_on_bus)};
                busy = 1'b0;
            end
            if (!busy) begin
                if (records_to_send.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct[records_to_send[0].phase]) begin
                    nxt = records_to_send.pop_front();
                    rec_on_bus = nxt;
                    i_start_time <= nxt.start_ts;
                    i_end_time <= nxt.end_ts;
                    i_nest_level <= nxt.depth;
                    i_first_record <= nxt.first;
                    cur_phase <= nxt.phase;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Takes result words and checks them against the oldest prediction.
    always @(posedge i_clk) begin
        self_res_t want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (predicted_self_times.size() == 0) begin
                    report_mismatch($sformatf("result word %0d with nothing predicted",
                                              results_seen));
                end else begin
                    want = predicted_self_times.pop_front();
                    if (o_self_time !== want.self_t)
                        report_mismatch($sformatf("word %0d self_time %h, want %h",
                                                  results_seen, o_self_time, want.self_t));
                    if (o_underflow !== want.under)
                        report_mismatch($sformatf("word %0d underflow %b, want %b",
                                                  results_seen, o_underflow, want.under));
                    if (o_level_overflow !== want.over)
                        report_mismatch($sformatf("word %0d level_overflow %b, want %b",
                                                  results_seen, o_level_overflow,
                                                  want.over));
                end
                results_seen++;
            end
            i_out_stall <= ($urandom_range(99) < rx_stall_pct[cur_phase]);
        end
    end

    // Ends the run if neither channel has moved a word for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_nested_trace_exclusive_time_core: FAIL");
            $finish;
        end
    end

    // Builds the stimulus, releases reset and waits for the last result.
    initial begin
        for (int j = 0; j < MAX_LEVELS; j++) child_time[j] = '0;
        last_depth = 0;

        // Directed records: window starts, every depth relation, clamping,
        // wrapping durations and accumulations, and the outermost and
        // innermost depths.
        add_rec(64'd0, 64'd0, 0, 1'b1, 0);
        add_rec(64'd100, 64'd250, 5, 1'b1, 0);
        add_rec(64'd110, 64'd140, 6, 1'b0, 0);
        add_rec(64'd150, 64'd170, 6, 1'b0, 0);
        add_rec(64'd100, 64'd300, 5, 1'b0, 0);
        add_rec(64'd90, 64'd260, 4, 1'b0, 0);
        add_rec(64'd0, {64{1'b1}}, 63, 1'b0, 0);
        add_rec(64'd1, 64'd0, 63, 1'b0, 0);
        add_rec(64'd0, {64{1'b1}}, 0, 1'b0, 0);
        add_rec(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0005, 10, 1'b0, 0);
        add_rec(64'd20, 64'd23, 2, 1'b0, 0);
        add_rec(64'd30, 64'd33, 1, 1'b0, 0);
        add_rec(64'd7, 64'd9, 1, 1'b1, 0);
        add_rec({64{1'b1}}, 64'd0, 63, 1'b1, 0);
        add_rec(64'd5, 64'd5, 62, 1'b0, 0);
        add_rec(64'd0, 64'h5555_5555_5555_5555, 0, 1'b0, 0);
        add_rec(64'hAAAA_AAAA_AAAA_AAAA, {64{1'b1}}, 63, 1'b0, 0);
        add_rec(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 42, 1'b1, 0);
        add_rec(64'h0000_0000_0000_0010, 64'h0000_0000_0000_0001, 21, 1'b0, 0);

        // Random part: mostly well-formed windows, some plain noise.
        for (int ph = 0; ph < 4; ph++) begin
            int goal;
            goal = records_to_send.size() + PHASE_ITEMS;
            while (records_to_send.size() < goal) begin
                if ($urandom_range(99) < 15)
                    add_rec(rand64(), rand64(), $urandom_range(63),
                            1'($urandom_range(1)), ph);
                else
                    gen_window(ph);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (records_to_send.size() != 0 || i_in_valid ||
               predicted_self_times.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (predicted_self_times.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      predicted_self_times.size()));

        if (mismatches == 0) begin
            $display("tb_nested_trace_exclusive_time_core: PASS");
        end else begin
            $display("tb_nested_trace_exclusive_time_core: FAIL");
        end
        $finish;
    end

endmodule
